// ===== hw/rtl/bitmap_page_allocator_core_assert.svh =====
// Assertion macros used by the bitmap page allocator checker.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define BPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// What must hold in the cycle after reset is sampled low.
`define BPA_ASSERT_RESET(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bpa_pkg.sv =====
// Types and constants of the bitmap page allocator.
`default_nettype none

package bpa_pkg;

  localparam int OP_W       = 3;
  localparam int PAGE_W     = 15;
  localparam int COUNT_W    = 16;
  localparam int CTR_W      = 32;
  localparam int WORD_BITS  = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 3'd0,
    OP_ALLOC_TBL  = 3'd1,
    OP_MARK_USED  = 3'd2,
    OP_FREE       = 3'd3,
    OP_ALLOC_RUN  = 3'd4,
    OP_FREE_RUN   = 3'd5
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TBL_FIRST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TBL_PAGES = 1'd1;

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_SCAN_RD = 8'b0000_0100,
    ST_SCAN_LD = 8'b0000_1000,
    ST_SCAN    = 8'b0001_0000,
    ST_FILL_RD = 8'b0010_0000,
    ST_FILL_WR = 8'b0100_0000,
    ST_RESP    = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_page_allocator_core.sv =====
// Bitmap page allocator: free map in a MAP_WORDS x 32 RAM, one request at a time.
// Allocations scan the map word by word through ST_SCAN_RD, ST_SCAN_LD and ST_SCAN,
// with an extra ST_SCAN visit per run edge met; the map update then reads and writes
// each word touched (ST_FILL_RD, ST_FILL_WR), and ST_RESP registers the result.
// A single mark or free raises out_tvalid with in_tready once ST_RESP loads the result.
// After reset the RAM is cleared one word per cycle, all MAP_WORDS words, in_tready low.
`default_nettype none

module bitmap_page_allocator_core #(
  parameter int MAP_WORDS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [14:0] page_index, [30:15] page_count, [31] zero
  input  logic [bpa_pkg::IN_DATA_W-1:0]  in_tdata,
  // [2:0] operation
  input  logic [bpa_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [14:0] found_page, [46:15] used_pages, [78:47] free_pages, [79] zero
  output logic [bpa_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] success
  output logic [0:0]                     out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bpa_pkg::*;

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW = AW + 5;
  localparam int RW = ((PW > COUNT_W) ? PW : COUNT_W) + 1;
  localparam logic [AW-1:0] LAST_W = AW'(MAP_WORDS - 1);
  localparam logic [RW-1:0] TOTAL  = RW'(MAP_WORDS * WORD_BITS);

  // Bits of word w whose pages fall in [lo, hi); the lowest page sits in the MSB.
  function automatic logic [WORD_BITS-1:0] range_mask(input logic [AW-1:0] w,
                                                      input logic [RW-1:0] lo,
                                                      input logic [RW-1:0] hi);
    logic [RW-1:0] b0;
    logic [RW-1:0] b1;
    logic [5:0]    s;
    logic [5:0]    e;
    b0 = RW'({w, 5'b0});
    b1 = b0 + RW'(WORD_BITS);
    s  = (lo <= b0) ? 6'd0 : ((lo >= b1) ? 6'd32 : {1'b0, lo[4:0]});
    e  = (hi <= b0) ? 6'd0 : ((hi >= b1) ? 6'd32 : {1'b0, hi[4:0]});
    return ({WORD_BITS{1'b1}} >> s) & ~({WORD_BITS{1'b1}} >> e);
  endfunction

  // Offset of the first set bit counting from the MSB, 32 when none is set.
  function automatic logic [5:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) begin
        n = 6'(WORD_BITS - 1 - i);
      end
    end
    return n;
  endfunction

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [AW-1:0]         w_r, w_nxt;
  logic [5:0]            pos_r, pos_nxt;
  logic                  in_run_r, in_run_nxt;
  logic [COUNT_W-1:0]    run_r, run_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PW-1:0]         start_r, start_nxt;
  logic [WORD_BITS-1:0]  elig_r, elig_nxt;
  logic [RW-1:0]         lo_r, lo_nxt;
  logic [RW-1:0]         hi_r, hi_nxt;
  logic                  ok_r, ok_nxt;
  logic [PAGE_W-1:0]     found_r, found_nxt;
  logic [CTR_W-1:0]      used_r, used_nxt;
  logic [CTR_W-1:0]      free_r, free_nxt;
  logic [PAGE_W-1:0]     first_r;
  logic [COUNT_W-1:0]    pages_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [PAGE_W-1:0]     out_found_r, out_found_nxt;
  logic [CTR_W-1:0]      out_used_r, out_used_nxt;
  logic [CTR_W-1:0]      out_free_r, out_free_nxt;

  logic                  ram_wr_en;
  logic                  ram_rd_en;
  logic [WORD_BITS-1:0]  ram_wr_data;
  logic [WORD_BITS-1:0]  ram_rd_data;

  op_t                   op_in;
  logic [RW-1:0]         page_in;
  logic [COUNT_W-1:0]    cnt_in;
  logic [RW-1:0]         tbl_lo;
  logic [RW-1:0]         tbl_hi;
  logic [RW-1:0]         mask_lo;
  logic [RW-1:0]         mask_hi;
  logic [WORD_BITS-1:0]  word_mask;
  logic [WORD_BITS-1:0]  seg;
  logic [5:0]            seg_pos;
  logic [5:0]            seg_len;
  logic [COUNT_W:0]      run_sum;
  logic                  run_hit;
  logic [RW-1:0]         hi_m1;
  logic                  fill_last;
  logic                  is_use;
  logic                  next_word;
  logic [CTR_W-1:0]      n_pages;

  assign op_in   = op_t'(in_tuser);
  assign page_in = RW'(in_tdata[PAGE_W-1:0]);
  assign cnt_in  = in_tdata[PAGE_W +: COUNT_W];
  assign tbl_lo  = RW'(first_r);
  assign tbl_hi  = RW'(first_r) + RW'(pages_r);

  // One range-mask unit serves both the page-table region and the fill range.
  assign mask_lo   = (state_r == ST_SCAN_LD) ? tbl_lo : lo_r;
  assign mask_hi   = (state_r == ST_SCAN_LD) ? tbl_hi : hi_r;
  assign word_mask = range_mask(w_r, mask_lo, mask_hi);

  // Inside a run look for its first ineligible page, otherwise for the next eligible one.
  assign seg       = (in_run_r ? ~elig_r : elig_r) & ({WORD_BITS{1'b1}} >> pos_r);
  assign seg_pos   = first_set(seg);
  assign seg_len   = seg_pos - pos_r;
  assign run_sum   = (COUNT_W+1)'(run_r) + (COUNT_W+1)'(seg_len);
  assign run_hit   = run_sum >= (COUNT_W+1)'(cnt_r);

  assign hi_m1     = hi_r - RW'(1);
  assign fill_last = (w_r == hi_m1[PW-1:5]);
  assign is_use    = (op_r == OP_ALLOC) || (op_r == OP_ALLOC_TBL) ||
                     (op_r == OP_MARK_USED) || (op_r == OP_ALLOC_RUN);
  assign n_pages   = CTR_W'(cnt_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    w_nxt         = w_r;
    pos_nxt       = pos_r;
    in_run_nxt    = in_run_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    start_nxt     = start_r;
    elig_nxt      = elig_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    ok_nxt        = ok_r;
    found_nxt     = found_r;
    used_nxt      = used_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_found_nxt = out_found_r;
    out_used_nxt  = out_used_r;
    out_free_nxt  = out_free_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    ram_wr_data   = '0;
    next_word     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_wr_en = 1'b1;
        if (w_r == LAST_W) begin
          w_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          w_nxt = w_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = op_in;
          ok_nxt     = 1'b0;
          found_nxt  = '0;
          w_nxt      = '0;
          pos_nxt    = '0;
          in_run_nxt = 1'b0;
          run_nxt    = '0;
          state_nxt  = ST_RESP;
          case (op_in)
            OP_ALLOC, OP_ALLOC_TBL: begin
              cnt_nxt   = COUNT_W'(1);
              state_nxt = ST_SCAN_RD;
            end
            OP_ALLOC_RUN: begin
              cnt_nxt = cnt_in;
              if (cnt_in != '0) begin
                state_nxt = ST_SCAN_RD;
              end
            end
            OP_MARK_USED, OP_FREE: begin
              cnt_nxt = COUNT_W'(1);
              lo_nxt  = page_in;
              hi_nxt  = page_in + RW'(1);
              w_nxt   = page_in[PW-1:5];
              if (page_in < TOTAL) begin
                state_nxt = ST_FILL_RD;
              end
            end
            OP_FREE_RUN: begin
              cnt_nxt = cnt_in;
              lo_nxt  = page_in;
              hi_nxt  = page_in + RW'(cnt_in);
              w_nxt   = page_in[PW-1:5];
              if ((cnt_in != '0) && (page_in + RW'(cnt_in) <= TOTAL)) begin
                state_nxt = ST_FILL_RD;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_SCAN_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_SCAN_LD;
      end
      ST_SCAN_LD: begin
        elig_nxt  = (op_r == OP_ALLOC_TBL) ? (ram_rd_data & word_mask)
                                           : (ram_rd_data & ~word_mask);
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!in_run_r) begin
          if (seg_pos[5]) begin
            next_word = 1'b1;
          end else begin
            in_run_nxt = 1'b1;
            run_nxt    = '0;
            pos_nxt    = seg_pos;
            start_nxt  = {w_r, seg_pos[4:0]};
          end
        end else if (run_hit) begin
          found_nxt = PAGE_W'(start_r);
          lo_nxt    = RW'(start_r);
          hi_nxt    = RW'(start_r) + RW'(cnt_r);
          w_nxt     = start_r[PW-1:5];
          state_nxt = ST_FILL_RD;
        end else begin
          run_nxt = run_sum[COUNT_W-1:0];
          if (seg_pos[5]) begin
            // The run carries on into the next word.
            next_word = 1'b1;
          end else begin
            in_run_nxt = 1'b0;
            pos_nxt    = seg_pos;
          end
        end
        if (next_word) begin
          if (w_r == LAST_W) begin
            state_nxt = ST_RESP;
          end else begin
            w_nxt     = w_r + AW'(1);
            pos_nxt   = '0;
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_FILL_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = is_use ? (ram_rd_data & ~word_mask) : (ram_rd_data | word_mask);
        if (fill_last) begin
          ok_nxt    = 1'b1;
          used_nxt  = is_use ? (used_r + n_pages) : (used_r - n_pages);
          free_nxt  = is_use ? (free_r - n_pages) : (free_r + n_pages);
          state_nxt = ST_RESP;
        end else begin
          w_nxt     = w_r + AW'(1);
          state_nxt = ST_FILL_RD;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_found_nxt = found_r;
          out_used_nxt  = used_r;
          out_free_nxt  = free_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      w_r         <= '0;
      used_r      <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
      first_r     <= '0;
      pages_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      used_r      <= used_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_TBL_FIRST) begin
          first_r <= cfg_data[PAGE_W-1:0];
        end else begin
          pages_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    in_run_r    <= in_run_nxt;
    run_r       <= run_nxt;
    cnt_r       <= cnt_nxt;
    start_r     <= start_nxt;
    elig_r      <= elig_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    ok_r        <= ok_nxt;
    found_r     <= found_nxt;
    out_ok_r    <= out_ok_nxt;
    out_found_r <= out_found_nxt;
    out_used_r  <= out_used_nxt;
    out_free_r  <= out_free_nxt;
  end

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (w_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (w_r),
    .rd_data (ram_rd_data)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_free_r, out_used_r, out_found_r};
  assign out_tuser  = out_ok_r;
  assign cfg_ready  = 1'b1;

endmodule

`default_nettype wire

// ===== hw/rtl/bpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bpa_checker.sv =====
// Port-level checker for the bitmap page allocator, bound to the top level.
`default_nettype none
`include "bitmap_page_allocator_core_assert.svh"

module bpa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bpa_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                     out_tuser
);

  // The block works on one request at a time.
  `BPA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "input ready right after a transaction")

  // A failed request reports page zero.
  `BPA_ASSERT_NOW(a_fail_page_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[14:0] == 15'd0, "failed result with nonzero page")

  // Every page taken from one counter goes to the other.
  `BPA_ASSERT_NOW(a_counters_balance, clk, rst_n, out_tvalid, (out_tdata[46:15] + out_tdata[78:47]) == 32'd0, "used and free counters out of balance")

  // Reset empties the result slot and starts the map clearing pass.
  `BPA_ASSERT_RESET(a_reset_quiet, clk, rst_n, !out_tvalid && !in_tready, "result or ready right after reset")

  `BPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the bitmap page allocator core.
module tb;
  import bpa_pkg::*;

  localparam int MAP_WORDS = 1024;
  localparam int TOTAL_PAGES = MAP_WORDS * WORD_BITS;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEMS_PER_PHASE = 85;
  // Worst case for one request: full scan with a run edge at every page, a full fill,
  // the long receiver hold and sender gaps.
  localparam longint ITEM_WORST = 5 * MAP_WORDS + TOTAL_PAGES + HOLD_CYCLES + 256;
  localparam longint CYCLE_LIMIT = 3 * 640 * ITEM_WORST + 4 * MAP_WORDS;

  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [PAGE_W-1:0] found_page;
    logic              success;
    logic [CTR_W-1:0]  used_pages;
    logic [CTR_W-1:0]  free_pages;
  } page_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the allocator state.
  bit          page_is_free [TOTAL_PAGES];
  bit [31:0]   used_count;
  bit [31:0]   free_count;
  int unsigned tbl_first;
  int unsigned tbl_pages;

  page_reply_t page_replies [$];
  page_reply_t want_reply;
  page_reply_t got_reply;
  int          mismatch_count = 0;
  int          burst_left = 0;
  longint      cycle_count = 0;

  bit hold_request = 1'b0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int rx_phase = 0;

  bitmap_page_allocator_core #(
    .MAP_WORDS(MAP_WORDS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit in_table(int unsigned p);
    return p >= tbl_first && p < tbl_first + tbl_pages;
  endfunction

  // Applies one request to the shadow state and returns the reply it must produce.
  function automatic page_reply_t apply_page_request(logic [OP_W-1:0] op_code,
                                                     logic [PAGE_W-1:0] page,
                                                     logic [COUNT_W-1:0] count);
    page_reply_t r;
    int unsigned p;
    int unsigned run_len;
    int unsigned start;
    bit hit;
    r = '0;
    hit = 1'b0;
    start = 0;
    run_len = 0;
    case (op_code)
      OP_ALLOC, OP_ALLOC_TBL: begin
        for (p = 0; p < TOTAL_PAGES && !hit; p++) begin
          if (page_is_free[p] && (in_table(p) == (op_code == OP_ALLOC_TBL))) begin
            hit = 1'b1;
            start = p;
          end
        end
        if (hit) begin
          page_is_free[start] = 1'b0;
          used_count += 1;
          free_count -= 1;
        end
      end
      OP_MARK_USED: begin
        if (page < TOTAL_PAGES) begin
          page_is_free[page] = 1'b0;
          used_count += 1;
          free_count -= 1;
          r.success = 1'b1;
        end
      end
      OP_FREE: begin
        if (page < TOTAL_PAGES) begin
          page_is_free[page] = 1'b1;
          used_count -= 1;
          free_count += 1;
          r.success = 1'b1;
        end
      end
      OP_ALLOC_RUN: begin
        if (count != 0) begin
          for (p = 0; p < TOTAL_PAGES && !hit; p++) begin
            if (page_is_free[p] && !in_table(p)) begin
              run_len++;
              if (run_len == count) begin
                hit = 1'b1;
                start = p + 1 - count;
              end
            end else begin
              run_len = 0;
            end
          end
        end
        if (hit) begin
          for (p = start; p < start + count; p++) page_is_free[p] = 1'b0;
          used_count += count;
          free_count -= count;
        end
      end
      OP_FREE_RUN: begin
        if (count != 0 && page + count <= TOTAL_PAGES) begin
          for (p = page; p < page + count; p++) page_is_free[p] = 1'b1;
          used_count -= count;
          free_count += count;
          r.success = 1'b1;
        end
      end
      default: ;
    endcase
    if (hit) begin
      r.success = 1'b1;
      r.found_page = PAGE_W'(start);
    end
    r.used_pages = used_count;
    r.free_pages = free_count;
    return r;
  endfunction

  // Sends one request; the sender runs in bursts separated by random gaps.
  task automatic send_request(input logic [OP_W-1:0] op_code, input logic [PAGE_W-1:0] page,
                              input logic [COUNT_W-1:0] count);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op_code;
    in_tdata <= {1'b0, count, page};
    do @(posedge clk); while (!in_tready);
    page_replies.push_back(apply_page_request(op_code, page, count));
    burst_left--;
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (page_replies.size() != 0) @(posedge clk);
  endtask

  // Writes both region registers while the block is idle.
  task automatic set_table_region(input logic [CFG_DATA_W-1:0] first_word,
                                  input logic [CFG_DATA_W-1:0] pages_word);
    drain_replies();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TBL_FIRST;
    cfg_data <= first_word;
    do @(posedge clk); while (!cfg_ready);
    tbl_first = first_word[PAGE_W-1:0];
    cfg_index <= CFG_TBL_PAGES;
    cfg_data <= pages_word;
    do @(posedge clk); while (!cfg_ready);
    tbl_pages = pages_word;
    cfg_valid <= 1'b0;
  endtask

  // Mostly small pages and counts near the bottom of the map keep scans short.
  task automatic send_random_request();
    int sel;
    logic [OP_W-1:0] op_code;
    logic [PAGE_W-1:0] page;
    logic [COUNT_W-1:0] count;
    sel = $urandom_range(0, 99);
    if (sel < 20) op_code = OP_ALLOC;
    else if (sel < 30) op_code = OP_ALLOC_TBL;
    else if (sel < 42) op_code = OP_MARK_USED;
    else if (sel < 64) op_code = OP_FREE;
    else if (sel < 78) op_code = OP_ALLOC_RUN;
    else if (sel < 96) op_code = OP_FREE_RUN;
    else if (sel < 98) op_code = OP_RSVD_6;
    else op_code = OP_RSVD_7;
    if ($urandom_range(0, 6) == 0) page = PAGE_W'($urandom_range(0, TOTAL_PAGES - 1));
    else page = PAGE_W'($urandom_range(0, 1023));
    sel = $urandom_range(0, 99);
    if (sel < 75) count = COUNT_W'($urandom_range(1, 8));
    else if (sel < 95) count = COUNT_W'($urandom_range(9, 64));
    else if (sel < 98) count = COUNT_W'($urandom_range(0, 65535));
    else count = '0;
    send_request(op_code, page, count);
  endtask

  task automatic test_directed_ops();
    send_request(OP_ALLOC, 15'd0, 16'd1);
    send_request(OP_ALLOC_TBL, 15'd0, 16'd1);
    send_request(OP_ALLOC_RUN, 15'd0, 16'd1);
    send_request(OP_FREE, 15'd0, 16'd1);
    send_request(OP_FREE, 15'd32767, 16'd1);
    send_request(OP_MARK_USED, 15'd32767, 16'd1);
    // Marking a page that is already used still moves the counters.
    send_request(OP_MARK_USED, 15'd32767, 16'd1);
    send_request(OP_FREE, 15'd5, 16'd1);
    send_request(OP_FREE, 15'd5, 16'd1);
    send_request(OP_ALLOC, 15'd0, 16'd1);
    send_request(OP_FREE_RUN, 15'd100, 16'd40);
    send_request(OP_ALLOC_RUN, 15'd0, 16'd0);
    send_request(OP_FREE_RUN, 15'd200, 16'd0);
    send_request(OP_FREE_RUN, 15'd32767, 16'd2);
    send_request(OP_FREE_RUN, 15'd32767, 16'd1);
    send_request(OP_ALLOC_RUN, 15'd0, 16'd10);
    send_request(OP_ALLOC_RUN, 15'd0, 16'd65535);
    send_request(OP_RSVD_6, 15'd32767, 16'd65535);
    send_request(OP_RSVD_7, 15'd1, 16'd1);
    // Free the whole map, then take it back as one run.
    send_request(OP_FREE_RUN, 15'd0, 16'd32768);
    send_request(OP_ALLOC_RUN, 15'd0, 16'd32768);
  endtask

  task automatic test_table_region();
    set_table_region(16'd64, 16'd32);
    send_request(OP_FREE_RUN, 15'd48, 16'd64);
    send_request(OP_ALLOC_TBL, 15'd0, 16'd1);
    send_request(OP_ALLOC, 15'd0, 16'd1);
    // The free pages below the region are too few, and a run may not cross it.
    send_request(OP_ALLOC_RUN, 15'd0, 16'd20);
    send_request(OP_ALLOC_RUN, 15'd0, 16'd16);
    set_table_region(16'hFFFF, 16'hFFFF);
    send_request(OP_FREE, 15'd32767, 16'd1);
    send_request(OP_ALLOC_TBL, 15'd0, 16'd1);
    set_table_region(16'd0, 16'd32768);
    send_request(OP_ALLOC, 15'd0, 16'd1);
    send_request(OP_ALLOC_TBL, 15'd0, 16'd1);
  endtask

  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] first_words [6];
    logic [CFG_DATA_W-1:0] pages_words [6];
    first_words[0] = 16'd0;
    pages_words[0] = 16'd0;
    first_words[1] = 16'd16;
    pages_words[1] = 16'd16;
    first_words[2] = {1'($urandom_range(0, 1)), 15'($urandom_range(0, 900))};
    pages_words[2] = 16'($urandom_range(1, 128));
    first_words[3] = 16'hFFFF;
    pages_words[3] = 16'hFFFF;
    first_words[4] = 16'd0;
    pages_words[4] = 16'd32768;
    first_words[5] = 16'($urandom_range(0, 65535));
    pages_words[5] = 16'($urandom_range(0, 65535));
    for (int ph = 0; ph < 6; ph++) begin
      set_table_region(first_words[ph], pages_words[ph]);
      repeat (ITEMS_PER_PHASE) send_random_request();
    end
  endtask

  // The receiver stops for a long stretch while the sender keeps offering requests.
  task automatic test_output_hold();
    set_table_region(16'd32, 16'd64);
    hold_request = 1'b1;
    burst_left = 40;
    repeat (30) send_random_request();
  endtask

  // Receiver stall pattern: stretches of always ready, random stalls and a fixed rhythm.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= (rx_phase % 4 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_reply.found_page = out_tdata[14:0];
      got_reply.success = out_tuser[0];
      got_reply.used_pages = out_tdata[46:15];
      got_reply.free_pages = out_tdata[78:47];
      if (page_replies.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected reply: page=%0d ok=%0d used=%0d free=%0d",
                   got_reply.found_page, got_reply.success,
                   got_reply.used_pages, got_reply.free_pages);
        end
        mismatch_count++;
      end else begin
        want_reply = page_replies.pop_front();
        if (got_reply.found_page !== want_reply.found_page ||
            got_reply.success !== want_reply.success ||
            got_reply.used_pages !== want_reply.used_pages ||
            got_reply.free_pages !== want_reply.free_pages) begin
          if (mismatch_count < 10) begin
            $display("reply mismatch: expected page=%0d ok=%0d used=%0d free=%0d",
                     want_reply.found_page, want_reply.success,
                     want_reply.used_pages, want_reply.free_pages);
            $display("                got      page=%0d ok=%0d used=%0d free=%0d",
                     got_reply.found_page, got_reply.success,
                     got_reply.used_pages, got_reply.free_pages);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < TOTAL_PAGES; p++) page_is_free[p] = 1'b0;
    used_count = '0;
    free_count = '0;
    tbl_first = 0;
    tbl_pages = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_table_region();
    test_random_phases();
    test_output_hold();
    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && page_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ram.sv
hw/rtl/bitmap_page_allocator_core.sv
hw/rtl/bpa_checker.sv
tb/sv/tb.sv
